// File: design/lphm_pkg.sv
//------------------------------------------------------------------------------
// lphm_pkg
// Shared types, request and status codes, and hash helpers for the
// linear probing hash map.
//------------------------------------------------------------------------------
`default_nettype none

package lphm_pkg;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} st_t;

	localparam logic [31:0] HASH_C1 = 32'h85ebca6b;
	localparam logic [31:0] HASH_C2 = 32'hc2b2ae35;

	typedef struct packed {
		logic load;
		logic res_zero;
		logic zero_op;
		logic clr_step;
		logic hash_a;
		logic hash_nk;
		logic hash_b;
		logic set_home;
		logic rd_en;
		logic rd_nb;
		logic probe_end;
		logic probe_next;
		logic del_end;
		logic del_latch;
		logic del_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic key_zero;
		logic rd_hit;
		logic rd_empty;
		logic clr_last;
	} sts_t;

	function automatic logic [31:0] hash_mix1(input logic [31:0] k);
		logic [31:0] t;
		t = k ^ (k >> 16);
		return t * HASH_C1;
	endfunction

	function automatic logic [31:0] hash_mix2(input logic [31:0] k);
		logic [31:0] t;
		t = k ^ (k >> 13);
		return t * HASH_C2;
	endfunction

	function automatic logic [31:0] hash_final(input logic [31:0] k);
		return k ^ (k >> 16);
	endfunction

endpackage

`default_nettype wire

// File: design/lphm_dp.sv
//------------------------------------------------------------------------------
// lphm_dp
// Datapath: slot memory, hash stages, probe and shift pointers, population
// count, zero-key cell and result registers.
//------------------------------------------------------------------------------
`default_nettype none

module lphm_dp import lphm_pkg::*; #(
	parameter int TABLE_SLOTS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] key,
	input  wire logic [31:0] value,
	output logic             done,
	output logic             found,
	output logic [31:0]      old_value,
	output logic [1:0]       status
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = AW + 1;
	localparam int LIMIT = (TABLE_SLOTS * 3) / 4;
	localparam logic [CW-1:0] FILL_AT = CW'(LIMIT - 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

	logic [31:0] key_mem [TABLE_SLOTS];
	logic [31:0] val_mem [TABLE_SLOTS];

	req_t          req_q;
	logic [31:0]   key_q, val_q, nk_q, nv_q, x1_q, x2_q, rkey_q, rval_q, zval_q, old_q;
	logic [AW-1:0] slot_q, hole_q, nb_q, clr_q;
	logic [CW-1:0] cnt_q;
	logic          zused_q, found_q, done_q;
	st_t           status_q;

	logic          we;
	logic [AW-1:0] waddr, raddr, ideal;
	logic [31:0]   wkey, wval, home_full;
	logic          would_fill, rd_hit, move;

	assign would_fill = cnt_q >= FILL_AT;
	assign rd_hit     = rkey_q == key_q;
	assign home_full  = hash_final(x2_q);
	assign ideal      = home_full[AW-1:0];
	assign move       = (hole_q - ideal) < (nb_q - ideal);
	assign raddr      = cmd.rd_nb ? nb_q : slot_q;

	assign sts.req      = req_q;
	assign sts.key_zero = key_q == 32'd0;
	assign sts.rd_hit   = rd_hit;
	assign sts.rd_empty = rkey_q == 32'd0;
	assign sts.clr_last = clr_q == LAST_SLOT;

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wkey  = 32'd0;
		wval  = 32'd0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.probe_end && req_q == REQ_INSERT && (rd_hit || !would_fill)) begin
			we    = 1'b1;
			waddr = slot_q;
			wkey  = key_q;
			wval  = val_q;
		end else if (cmd.del_end) begin
			we    = 1'b1;
			waddr = hole_q;
		end else if (cmd.del_step && move) begin
			we    = 1'b1;
			waddr = hole_q;
			wkey  = nk_q;
			wval  = nv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
		if (cmd.rd_en) begin
			rkey_q <= key_mem[raddr];
			rval_q <= val_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_t'(req_type);
			key_q <= key;
			val_q <= value;
		end
		if (cmd.hash_a) begin
			x1_q <= hash_mix1(cmd.hash_nk ? nk_q : key_q);
		end
		if (cmd.hash_b) begin
			x2_q <= hash_mix2(x1_q);
		end
		if (cmd.set_home) begin
			slot_q <= ideal;
		end else if (cmd.probe_next) begin
			slot_q <= slot_q + AW'(1);
		end
		if (cmd.probe_end) begin
			hole_q <= slot_q;
			nb_q   <= slot_q + AW'(1);
		end else if (cmd.del_step) begin
			if (move) begin
				hole_q <= nb_q;
			end
			nb_q <= nb_q + AW'(1);
		end
		if (cmd.del_latch) begin
			nk_q <= rkey_q;
			nv_q <= rval_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			cnt_q    <= '0;
			zused_q  <= 1'b0;
			zval_q   <= 32'd0;
			found_q  <= 1'b0;
			old_q    <= 32'd0;
			status_q <= ST_OK;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.clr_step) begin
				clr_q   <= clr_q + AW'(1);
				cnt_q   <= '0;
				zused_q <= 1'b0;
				zval_q  <= 32'd0;
			end
			if (cmd.res_zero) begin
				found_q  <= 1'b0;
				old_q    <= 32'd0;
				status_q <= ST_OK;
			end
			if (cmd.zero_op) begin
				found_q  <= zused_q;
				old_q    <= zused_q ? zval_q : 32'd0;
				status_q <= ST_OK;
				case (req_q)
					REQ_INSERT: begin
						if (zused_q) begin
							zval_q <= val_q;
						end else if (would_fill) begin
							status_q <= ST_FULL;
						end else begin
							zused_q <= 1'b1;
							zval_q  <= val_q;
							cnt_q   <= cnt_q + CW'(1);
						end
					end
					REQ_DELETE: begin
						if (zused_q) begin
							zused_q <= 1'b0;
							zval_q  <= 32'd0;
							cnt_q   <= cnt_q - CW'(1);
						end else begin
							status_q <= ST_NOT_FOUND;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.probe_end) begin
				found_q  <= rd_hit;
				old_q    <= rd_hit ? rval_q : 32'd0;
				status_q <= ST_OK;
				case (req_q)
					REQ_INSERT: begin
						if (!rd_hit) begin
							if (would_fill) begin
								status_q <= ST_FULL;
							end else begin
								cnt_q <= cnt_q + CW'(1);
							end
						end
					end
					REQ_DELETE: begin
						if (!rd_hit) begin
							status_q <= ST_NOT_FOUND;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.del_end) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign done      = done_q;
	assign found     = found_q;
	assign old_value = old_q;
	assign status    = status_q;

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(LIMIT))
		else $error("population reached the load limit");

	a_zero_counted: assert property (@(posedge clk) disable iff (!arst_n)
		zused_q |-> cnt_q != '0)
		else $error("zero cell in use but population is zero");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && found_q |-> status_q == ST_OK)
		else $error("present key reported with an error status");

endmodule

`default_nettype wire

// File: design/lphm_ctrl.sv
//------------------------------------------------------------------------------
// lphm_ctrl
// Controller: sequences hashing, probing, backward-shift delete and the
// table clearing sweep.
//------------------------------------------------------------------------------
`default_nettype none

module lphm_ctrl import lphm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_DISP = 13'b0000000000010,
		S_CLR  = 13'b0000000000100,
		S_HA   = 13'b0000000001000,
		S_HB   = 13'b0000000010000,
		S_HOME = 13'b0000000100000,
		S_PRD  = 13'b0000001000000,
		S_PCMP = 13'b0000010000000,
		S_DRD  = 13'b0000100000000,
		S_DCHK = 13'b0001000000000,
		S_DHA  = 13'b0010000000000,
		S_DHB  = 13'b0100000000000,
		S_DCMP = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   report_q, report_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		report_d = report_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.req == REQ_CLEAR) begin
					cmd.res_zero = 1'b1;
					report_d     = 1'b1;
					state_d      = S_CLR;
				end else if (sts.key_zero) begin
					cmd.zero_op = 1'b1;
					cmd.finish  = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.hash_a = 1'b1;
					state_d    = S_HB;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.finish = report_q;
					report_d   = 1'b0;
					state_d    = S_IDLE;
				end
			end
			S_HA: begin
				cmd.hash_a = 1'b1;
				state_d    = S_HB;
			end
			S_HB: begin
				cmd.hash_b = 1'b1;
				state_d    = S_HOME;
			end
			S_HOME: begin
				cmd.set_home = 1'b1;
				state_d      = S_PRD;
			end
			S_PRD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_PCMP;
			end
			S_PCMP: begin
				if (sts.rd_hit || sts.rd_empty) begin
					cmd.probe_end = 1'b1;
					if (sts.req == REQ_DELETE && sts.rd_hit) begin
						state_d = S_DRD;
					end else begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_PRD;
				end
			end
			S_DRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_nb = 1'b1;
				state_d   = S_DCHK;
			end
			S_DCHK: begin
				if (sts.rd_empty) begin
					cmd.del_end = 1'b1;
					cmd.finish  = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.del_latch = 1'b1;
					state_d       = S_DHA;
				end
			end
			S_DHA: begin
				cmd.hash_a  = 1'b1;
				cmd.hash_nk = 1'b1;
				state_d     = S_DHB;
			end
			S_DHB: begin
				cmd.hash_b = 1'b1;
				state_d    = S_DCMP;
			end
			S_DCMP: begin
				cmd.del_step = 1'b1;
				state_d      = S_DRD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			report_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			report_q <= report_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

// File: design/linear_probe_hash_map.sv
//------------------------------------------------------------------------------
// linear_probe_hash_map
// Integer key to value map with circular linear probing, a separate zero-key
// cell and backward-shift delete.
//
// Channel   Handshake        Signals
// request   start, busy      req_type, key, value
// result    done (strobe)    found, old_value, status
//
// A lookup or insert hashes the key and probes slots from its home slot until it
// finds the key or an empty slot. A delete of a present key then scans the slots
// after it and rehashes the home slot of each occupied one through two multiply
// stages. Clear sweeps the table one slot per cycle through the single write
// port. After reset the same sweep runs with busy high. Results cannot be stalled.
//------------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_map import lphm_pkg::*; #(
	parameter int TABLE_SLOTS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] key,
	input  wire logic [31:0] value,
	output logic             done,
	output logic             found,
	output logic [31:0]      old_value,
	output logic [1:0]       status
);

	cmd_t cmd;
	sts_t sts;

	lphm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	lphm_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req_type),
		.key       (key),
		.value     (value),
		.done      (done),
		.found     (found),
		.old_value (old_value),
		.status    (status)
	);

endmodule

`default_nettype wire
